>>> hdl/ipfmt_pkg.sv
// shared types, character codes and digit helpers for the ip address text formatter
`timescale 1ns / 1ps
`default_nettype none
package ipfmt_pkg;

  localparam int unsigned NumWords  = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned V6W       = NumWords * WordW;
  localparam int unsigned V4W       = 32;
  localparam int unsigned CharW     = 7;

  localparam logic [CharW-1:0] ChColon = 7'h3a;
  localparam logic [CharW-1:0] ChDot   = 7'h2e;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChNine  = 7'h39;
  localparam logic [CharW-1:0] ChLowA  = 7'h61;
  localparam logic [CharW-1:0] ChLowF  = 7'h66;

  localparam logic [2:0] LastV6Word = 3'd7;
  localparam logic [2:0] LastV4Word = 3'd3;

  // what kind of character the datapath puts out
  typedef enum logic [1:0] {
    KIND_COLON = 2'd0,
    KIND_DOT   = 2'd1,
    KIND_DIGIT = 2'd2
  } ch_kind_e;

  typedef struct packed {
    logic       load;
    logic       emit;
    ch_kind_e   kind;
    logic [2:0] k;
    logic [1:0] d;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_v6;
    logic       word_zero;
    logic [1:0] ndig_m1;
    logic       nz_after;
    logic [2:0] next_k;
    logic       out_free;
  } dp_status_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) c = ChZero + {3'b000, nib};
    else             c = ChLowA + {3'b000, nib - 4'd10};
    return c;
  endfunction

  // decimal digit d of an octet (2 = hundreds, 1 = tens, 0 = ones)
  function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] d);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [6:0]  tens10;
    logic [3:0]  o;
    logic [3:0]  res;
    if (v >= 8'd200)      h = 2'd2;
    else if (v >= 8'd100) h = 2'd1;
    else                  h = 2'd0;
    r      = 7'(v - 8'(h) * 8'd100);
    // r * 205 >> 11 equals r / 10 for r below 100
    prod   = 15'(r) * 15'd205;
    t      = prod[14:11];
    tens10 = 7'(t) * 7'd10;
    o      = 4'(r - tens10);
    case (d)
      2'd2:    res = {2'b00, h};
      2'd1:    res = t;
      default: res = o;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ipfmt_dp.sv
// datapath: address registers, digit extraction and output beat register
`timescale 1ns / 1ps
`default_nettype none
module ipfmt_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          is_ipv6_i,
  input  wire  [63:0]                  ipv6_high_i,
  input  wire  [63:0]                  ipv6_low_i,
  input  wire  [31:0]                  ipv4_addr_i,
  input  wire  ipfmt_pkg::dp_cmd_t     cmd_i,
  output ipfmt_pkg::dp_status_t        status_o,
  input  wire                          out_stall_i,
  output logic                         out_valid_o,
  output logic [ipfmt_pkg::CharW-1:0]  char_code_o,
  output logic                         last_char_o
);
  import ipfmt_pkg::*;

  logic             v6_sel_q;
  logic [V6W-1:0]   v6_q;
  logic [V4W-1:0]   v4_q;
  logic             out_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  logic [WordW-1:0]    word;
  logic [7:0]          octet;
  logic [NumWords-1:0] zmask;
  logic [3:0]          nib;
  logic [CharW-1:0]    ch;
  logic                nz_after;
  logic [2:0]          next_k;
  logic [1:0]          ndig_hex;
  logic [1:0]          ndig_dec;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v6_sel_q <= is_ipv6_i;
      v6_q     <= {ipv6_high_i, ipv6_low_i};
      v4_q     <= ipv4_addr_i;
    end
    if (cmd_i.emit) begin
      char_q <= ch;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // word 0 sits in the top bits
  assign word  = v6_q[{3'd7 - cmd_i.k, 4'b0000} +: WordW];
  assign octet = v4_q[{2'd3 - cmd_i.k[1:0], 3'b000} +: 8];

  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      zmask[i] = (v6_q[(NumWords-1-i)*WordW +: WordW] == '0);
    end
  end

  // first nonzero word after the current one
  always_comb begin
    nz_after = 1'b0;
    next_k   = '0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if ((3'(i) > cmd_i.k) && !zmask[i]) begin
        nz_after = 1'b1;
        next_k   = 3'(i);
      end
    end
  end

  always_comb begin
    if (word[15:12] != '0)     ndig_hex = 2'd3;
    else if (word[11:8] != '0) ndig_hex = 2'd2;
    else if (word[7:4] != '0)  ndig_hex = 2'd1;
    else                       ndig_hex = 2'd0;
    if (octet >= 8'd100)       ndig_dec = 2'd2;
    else if (octet >= 8'd10)   ndig_dec = 2'd1;
    else                       ndig_dec = 2'd0;
  end

  assign nib = word[{cmd_i.d, 2'b00} +: 4];

  always_comb begin
    case (cmd_i.kind)
      KIND_COLON: ch = ChColon;
      KIND_DOT:   ch = ChDot;
      KIND_DIGIT: ch = v6_sel_q ? hex_char(nib) : (ChZero + {3'b000, dec_digit(octet, cmd_i.d)});
      default:    ch = ChColon;
    endcase
  end

  assign status_o.is_v6     = v6_sel_q;
  assign status_o.word_zero = zmask[cmd_i.k];
  assign status_o.ndig_m1   = v6_sel_q ? ndig_hex : ndig_dec;
  assign status_o.nz_after  = nz_after;
  assign status_o.next_k    = next_k;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule
`default_nettype wire

>>> hdl/ipfmt_ctrl.sv
// controller: walks words and digits, at most one character beat per step
`timescale 1ns / 1ps
`default_nettype none
module ipfmt_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       busy_o,
  input  wire  ipfmt_pkg::dp_status_t status_i,
  output ipfmt_pkg::dp_cmd_t          cmd_o
);
  import ipfmt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEP    = 2'd1;
  localparam logic [1:0] ST_DIG    = 2'd2;
  localparam logic [1:0] ST_ELIDE2 = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [1:0] d_q, d_d;
  logic       elided_q, elided_d;
  logic       last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      k_q      <= '0;
      d_q      <= '0;
      elided_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      d_q      <= d_d;
      elided_q <= elided_d;
    end
  end

  assign last_word = (k_q == (status_i.is_v6 ? LastV6Word : LastV4Word));

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    d_d        = d_q;
    elided_d   = elided_q;
    cmd_o      = '0;
    cmd_o.kind = KIND_COLON;
    cmd_o.k    = k_q;
    cmd_o.d    = d_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEP;
          k_d        = '0;
          elided_d   = 1'b0;
        end
      end
      ST_SEP: begin
        if (status_i.is_v6 && status_i.word_zero && !elided_q) begin
          // first zero run collapses to a single colon here
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            elided_d   = 1'b1;
            if (status_i.nz_after) k_d = status_i.next_k;
            else                   state_d = ST_ELIDE2;
          end
        end else if (k_q == '0) begin
          state_d = ST_DIG;
          d_d     = status_i.ndig_m1;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = status_i.is_v6 ? KIND_COLON : KIND_DOT;
          state_d    = ST_DIG;
          d_d        = status_i.ndig_m1;
        end
      end
      ST_DIG: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_DIGIT;
          cmd_o.last = (d_q == '0) && last_word;
          if (d_q == '0) begin
            if (last_word) begin
              state_d = ST_IDLE;
            end else begin
              k_d     = k_q + 3'd1;
              state_d = ST_SEP;
            end
          end else begin
            d_d = d_q - 2'd1;
          end
        end
      end
      ST_ELIDE2: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

>>> hdl/ip_address_text_formatter_core.sv
// top level: ip address to text formatter, one ascii character per output beat
// the address is loaded as the input beat is accepted; each character is registered
// in the output beat register. throughput: one character per cycle while the output
// is not stalled, as a stalled beat holds the controller; one character per step
// one address is in work at a time; a new input beat is taken once the last char is issued
// reset: asynchronous active-low, clears the controller state and the output valid
`timescale 1ns / 1ps
`default_nettype none
module ip_address_text_formatter_core (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire                         is_ipv6_i,
  input  wire  [63:0]                 ipv6_high_i,
  input  wire  [63:0]                 ipv6_low_i,
  input  wire  [31:0]                 ipv4_addr_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [ipfmt_pkg::CharW-1:0] char_code_o,
  output logic                        last_char_o
);
  import ipfmt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy;

  ipfmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (busy),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ipfmt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .is_ipv6_i   (is_ipv6_i),
    .ipv6_high_i (ipv6_high_i),
    .ipv6_low_i  (ipv6_low_i),
    .ipv4_addr_i (ipv4_addr_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  assign in_stall_o = busy;

  // an accepted address keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input beat accepted but block not busy");

  // every character is a hex digit, a decimal digit, a colon or a dot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == ChColon || char_code_o == ChDot ||
                     (char_code_o >= ChZero && char_code_o <= ChNine) ||
                     (char_code_o >= ChLowA && char_code_o <= ChLowF)))
    else $error("illegal character code");

  // a new character only comes out of work on an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat while idle");

endmodule
`default_nettype wire
